FILE: rtl/utf8e_pkg.sv
package utf8e_pkg;

   // output budget, one byte always kept for the terminator
   localparam int BUFFER_BYTES = 256;
   localparam int CNT_W        = $clog2(BUFFER_BYTES);
   localparam int TOTAL_LEN_W  = 9;
   localparam int SUM_W        = (CNT_W + 1 > TOTAL_LEN_W) ? CNT_W + 1 : TOTAL_LEN_W;

   localparam int CP_W     = 31;
   localparam int SEQ_N_W  = 3;
   localparam int FIFO_DEPTH = 2;

   localparam logic FUNC_CODE_POINT = 1'b0;
   localparam logic FUNC_END        = 1'b1;

   // upper bounds of each sequence length
   localparam logic [CP_W-1:0] MAX_1_BYTE = 31'h0000_007F;
   localparam logic [CP_W-1:0] MAX_2_BYTE = 31'h0000_07FF;
   localparam logic [CP_W-1:0] MAX_3_BYTE = 31'h0000_FFFF;
   localparam logic [CP_W-1:0] MAX_4_BYTE = 31'h001F_FFFF;
   localparam logic [CP_W-1:0] MAX_5_BYTE = 31'h03FF_FFFF;

   localparam logic [7:0] LEAD_MARK_2 = 8'hC0;
   localparam logic [7:0] LEAD_MARK_3 = 8'hE0;
   localparam logic [7:0] LEAD_MARK_4 = 8'hF0;
   localparam logic [7:0] LEAD_MARK_5 = 8'hF8;
   localparam logic [7:0] LEAD_MARK_6 = 8'hFC;
   localparam logic [7:0] CONT_MARK   = 8'h80;
   localparam logic [7:0] CONT_MASK   = 8'h3F;

   typedef struct packed {
      logic            func;
      logic [CP_W-1:0] code_point;
   } req_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   byte_valid;
      logic                   seq_last;
      logic                   overflow;
      logic [TOTAL_LEN_W-1:0] total_length;
   } rsp_type;

   // one classified transaction waiting for the serializer
   typedef struct packed {
      logic                   is_end;
      logic                   overflow;
      logic [TOTAL_LEN_W-1:0] total_length;
      logic [SEQ_N_W-1:0]     seq_n;
      logic [CP_W-1:0]        code_point;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

FILE: rtl/utf8e_front.sv
module utf8e_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  utf8e_pkg::req_type         req_data,
   input  utf8e_pkg::fifo_status_type fifo_status,
   output logic                       push,
   output utf8e_pkg::job_type         push_job
);

   logic [utf8e_pkg::CNT_W-1:0]   bytes_written_ff, bytes_written_in;
   logic                          overflowed_ff, overflowed_in;
   logic                          accept;
   logic [utf8e_pkg::SEQ_N_W-1:0] seq_n;
   logic [utf8e_pkg::SUM_W-1:0]   sum_seq;
   logic [utf8e_pkg::SUM_W-1:0]   sum_need;
   logic [utf8e_pkg::SUM_W-1:0]   sum_term;
   logic                          over_budget;

   assign req_stall = fifo_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (req_data.code_point <= utf8e_pkg::MAX_1_BYTE) begin
         seq_n = 3'd1;
      end else if (req_data.code_point <= utf8e_pkg::MAX_2_BYTE) begin
         seq_n = 3'd2;
      end else if (req_data.code_point <= utf8e_pkg::MAX_3_BYTE) begin
         seq_n = 3'd3;
      end else if (req_data.code_point <= utf8e_pkg::MAX_4_BYTE) begin
         seq_n = 3'd4;
      end else if (req_data.code_point <= utf8e_pkg::MAX_5_BYTE) begin
         seq_n = 3'd5;
      end else begin
         seq_n = 3'd6;
      end
   end

   assign sum_seq     = utf8e_pkg::SUM_W'(bytes_written_ff) + utf8e_pkg::SUM_W'(seq_n);
   assign sum_need    = sum_seq + utf8e_pkg::SUM_W'(1);
   assign sum_term    = utf8e_pkg::SUM_W'(bytes_written_ff) + utf8e_pkg::SUM_W'(1);
   assign over_budget = sum_need > utf8e_pkg::SUM_W'(utf8e_pkg::BUFFER_BYTES);

   always_comb begin
      bytes_written_in      = bytes_written_ff;
      overflowed_in         = overflowed_ff;
      push                  = 1'b0;
      push_job.is_end       = 1'b0;
      push_job.overflow     = 1'b0;
      push_job.total_length = '0;
      push_job.seq_n        = seq_n;
      push_job.code_point   = req_data.code_point;
      if (accept) begin
         if (req_data.func == utf8e_pkg::FUNC_END) begin
            push            = 1'b1;
            push_job.is_end = 1'b1;
            if (overflowed_ff) begin
               push_job.overflow = 1'b1;
            end else begin
               push_job.total_length = sum_term[utf8e_pkg::TOTAL_LEN_W-1:0];
            end
            bytes_written_in = '0;
            overflowed_in    = 1'b0;
         end else if (!overflowed_ff) begin
            if (over_budget) begin
               overflowed_in = 1'b1;
            end else begin
               push             = 1'b1;
               bytes_written_in = sum_seq[utf8e_pkg::CNT_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_written_ff <= '0;
         overflowed_ff    <= 1'b0;
      end else begin
         bytes_written_ff <= bytes_written_in;
         overflowed_ff    <= overflowed_in;
      end
   end

endmodule

FILE: rtl/utf8e_fifo.sv
module utf8e_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  utf8e_pkg::job_type         push_job,
   input  logic                       pop,
   output utf8e_pkg::job_type         head_job,
   output utf8e_pkg::fifo_status_type fifo_status
);

   localparam int PTR_W = $clog2(utf8e_pkg::FIFO_DEPTH);
   localparam int CNT_W = $clog2(utf8e_pkg::FIFO_DEPTH + 1);

   utf8e_pkg::job_type entry_ff [utf8e_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign fifo_status.full  = count_ff == CNT_W'(utf8e_pkg::FIFO_DEPTH);
   assign fifo_status.empty = count_ff == '0;
   assign do_push = push && !fifo_status.full;
   assign do_pop  = pop && !fifo_status.empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(utf8e_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(utf8e_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/utf8e_back.sv
module utf8e_back (
   input  logic                       clock,
   input  logic                       reset,
   input  utf8e_pkg::job_type         head_job,
   input  utf8e_pkg::fifo_status_type fifo_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output utf8e_pkg::rsp_type         rsp_data
);

   logic [utf8e_pkg::SEQ_N_W-1:0] k_ff, k_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   utf8e_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                          out_free, emit, last_byte;
   logic [utf8e_pkg::SEQ_N_W-1:0] r;
   logic [5:0]                    group;
   logic [7:0]                    lead;
   logic [utf8e_pkg::CP_W-1:0]    cp;

   assign cp        = head_job.code_point;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = out_free && !fifo_status.empty;
   assign last_byte = head_job.is_end || (k_ff == head_job.seq_n - 3'd1);
   assign pop       = emit && last_byte;
   // six-bit group index counted from the low end
   assign r         = head_job.seq_n - 3'd1 - k_ff;

   always_comb begin
      case (r)
         3'd0:    group = cp[5:0];
         3'd1:    group = cp[11:6];
         3'd2:    group = cp[17:12];
         3'd3:    group = cp[23:18];
         3'd4:    group = cp[29:24];
         default: group = 6'd0;
      endcase
   end

   always_comb begin
      case (head_job.seq_n)
         3'd1:    lead = {1'b0, cp[6:0]};
         3'd2:    lead = utf8e_pkg::LEAD_MARK_2 | {3'b000, cp[10:6]};
         3'd3:    lead = utf8e_pkg::LEAD_MARK_3 | {4'b0000, cp[15:12]};
         3'd4:    lead = utf8e_pkg::LEAD_MARK_4 | {5'b00000, cp[20:18]};
         3'd5:    lead = utf8e_pkg::LEAD_MARK_5 | {6'b000000, cp[25:24]};
         default: lead = utf8e_pkg::LEAD_MARK_6 | {7'b0000000, cp[30]};
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (head_job.is_end) begin
         rsp_data_in.out_byte     = 8'h00;
         rsp_data_in.byte_valid   = !head_job.overflow;
         rsp_data_in.seq_last     = 1'b1;
         rsp_data_in.overflow     = head_job.overflow;
         rsp_data_in.total_length = head_job.total_length;
      end else begin
         rsp_data_in.out_byte     = (k_ff == '0) ? lead
                                    : (utf8e_pkg::CONT_MARK | ({2'b00, group} &
                                       utf8e_pkg::CONT_MASK));
         rsp_data_in.byte_valid   = 1'b1;
         rsp_data_in.seq_last     = last_byte;
         rsp_data_in.overflow     = 1'b0;
         rsp_data_in.total_length = '0;
      end
   end

   always_comb begin
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in = 1'b1;
         k_in         = last_byte ? '0 : k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/code_point_to_utf8_encoder_core.sv
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_data (func, code_point)
// rsp      out        rsp_valid/rsp_stall  rsp_data (byte, flags, total length)
//
// a transaction is taken every cycle while the two-entry job queue has room
// the serializer emits one byte per cycle unless rsp_stall holds it, so the sustained rate
// is one output byte per cycle; a first byte passes the job queue and then the output register
// a code point after overflow, or one that overflows, gives no output and is not queued
// reset clears the byte count, the overflow flag, the queue and the output valid flag
// rsp_stall holds the output register; req_stall rises only when the queue is full
module code_point_to_utf8_encoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  utf8e_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output utf8e_pkg::rsp_type  rsp_data
);

   utf8e_pkg::fifo_status_type fifo_status;
   utf8e_pkg::job_type         push_job;
   utf8e_pkg::job_type         head_job;
   logic                       push;
   logic                       pop;

   utf8e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_job    (push_job)
   );

   utf8e_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_job    (push_job),
      .pop         (pop),
      .head_job    (head_job),
      .fifo_status (fifo_status)
   );

   utf8e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
